// File: hw/rtl/adam_pkg.sv
// adam_pkg: shared types and codes for the adam optimizer update block
// no dependencies; used by adam_queue, adam_front, adam_back and adam_optimizer_update
`timescale 1ns / 1ps

package adam_pkg;

  // configuration register indexes
  localparam logic [7:0] CFG_STEP_SIZE    = 8'd0;
  localparam logic [7:0] CFG_BETA_FIRST   = 8'd1;
  localparam logic [7:0] CFG_BETA_SECOND  = 8'd2;
  localparam logic [7:0] CFG_EPSILON_TERM = 8'd3;

  localparam logic [31:0] LR_RESET  = 32'd4295;
  localparam logic [15:0] BF_RESET  = 16'd58982;
  localparam logic [15:0] BS_RESET  = 16'd65470;
  localparam logic [31:0] EPS_RESET = 32'd43;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  typedef struct packed {
    logic [31:0] step_size;
    logic [15:0] beta_first;
    logic [15:0] beta_second;
    logic [31:0] epsilon_term;
  } cfg_t;

  // one classified item between front and back
  typedef struct packed {
    logic [11:0]        idx;
    logic [11:0]        pidx;
    logic signed [31:0] value;
    logic signed [31:0] grad;
    logic signed [31:0] scale;
    logic               start;
  } qitem_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MOD,
    FR_PUSH
  } front_state_t;

  typedef enum logic [4:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_G,
    BK_M1,
    BK_M2,
    BK_GG,
    BK_V1,
    BK_V2,
    BK_V3,
    BK_V4,
    BK_WB,
    BK_DIV1,
    BK_DIV2,
    BK_SQRT,
    BK_DIV3,
    BK_L1,
    BK_L2,
    BK_FIN
  } back_state_t;

endpackage

// File: hw/rtl/adam_queue.sv
// adam_queue: two-entry queue of classified items between front and back
// depends on adam_pkg
`timescale 1ns / 1ps

module adam_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  adam_pkg::qitem_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output adam_pkg::qitem_t head
);

  adam_pkg::qitem_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && not_empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
    end
  end

endmodule

// File: hw/rtl/adam_front.sv
// adam_front: takes input beats, folds the index into the store range, queues the item
// depends on adam_pkg
`timescale 1ns / 1ps

module adam_front #(
  parameter int PARAM_COUNT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        param_index,
  input  logic signed [31:0] param_value,
  input  logic signed [31:0] gradient,
  input  logic signed [31:0] grad_mult,
  input  logic               step_start,
  input  logic               clearing,
  output logic               push,
  output adam_pkg::qitem_t   push_item,
  input  logic               q_full
);

  localparam logic [32:0] PC33  = 33'(PARAM_COUNT);
  // floor(2^24 / PARAM_COUNT): the quotient estimate is exact or one low
  localparam logic [24:0] RECIP = 25'((64'd1 << 24) / 64'(PARAM_COUNT));

  adam_pkg::front_state_t state, state_next;
  adam_pkg::qitem_t hold;
  logic [11:0] quot;
  logic [11:0] rem;
  logic [11:0] folded;
  logic        take;

  // remainder estimate lies below twice the modulus, one correction finishes it
  assign folded    = ({21'd0, rem} >= PC33) ? rem - PC33[11:0] : rem;
  assign push_item = '{idx: folded, pidx: hold.pidx, value: hold.value, grad: hold.grad,
                       scale: hold.scale, start: hold.start};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adam_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    push       = 1'b0;
    take       = 1'b0;
    case (state)
      adam_pkg::FR_IDLE: begin
        in_stall = clearing;
        if (in_valid && !clearing) begin
          take       = 1'b1;
          state_next = adam_pkg::FR_MOD;
        end
      end
      adam_pkg::FR_MOD: begin
        state_next = adam_pkg::FR_PUSH;
      end
      adam_pkg::FR_PUSH: begin
        if (!q_full) begin
          push       = 1'b1;
          state_next = adam_pkg::FR_IDLE;
        end
      end
      default: state_next = adam_pkg::FR_IDLE;
    endcase
  end

  // reciprocal multiply for the quotient, then the remainder estimate
  always_ff @(posedge clk) begin
    if (take) begin
      hold <= '{idx: param_index, pidx: param_index, value: param_value, grad: gradient,
                 scale: grad_mult, start: step_start};
      quot <= 12'((37'(param_index) * 37'(RECIP)) >> 24);
    end else if (state == adam_pkg::FR_MOD) begin
      rem <= hold.pidx - 12'(33'(quot) * PC33);
    end
  end

endmodule

// File: hw/rtl/adam_div.sv
// adam_div: saturating radix-4 restoring divider, floor(num * 2^32 / den)
// depends on nothing beyond the timescale
`timescale 1ns / 1ps

module adam_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [49:0] den,
  output logic        done,
  output logic [63:0] quo
);

  localparam int STEPS = 2;
  localparam int ITER  = 96 / STEPS;
  localparam logic [5:0] LAST = 6'(ITER - 1);

  logic [63:0] nsh, nsh_next;
  logic [49:0] rem, rem_next;
  logic [49:0] dd;
  logic [63:0] q, q_next;
  logic        over, over_next;
  logic [5:0]  cnt;
  logic        busy;

  assign quo = over ? {64{1'b1}} : q;

  always_comb begin
    logic [50:0] r2;
    r2        = '0;
    nsh_next  = nsh;
    rem_next  = rem;
    q_next    = q;
    over_next = over;
    for (int s = 0; s < STEPS; s++) begin
      r2       = {rem_next, nsh_next[63]};
      nsh_next = {nsh_next[62:0], 1'b0};
      if (q_next[63]) begin
        over_next = 1'b1;
      end
      q_next = {q_next[62:0], 1'b0};
      if (r2 >= {1'b0, dd}) begin
        r2        = r2 - {1'b0, dd};
        q_next[0] = 1'b1;
      end
      rem_next = r2[49:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= num;
      dd   <= den;
      rem  <= '0;
      q    <= '0;
      over <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      nsh  <= nsh_next;
      rem  <= rem_next;
      q    <= q_next;
      over <= over_next;
      cnt  <= cnt + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LAST) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/adam_sqrt.sv
// adam_sqrt: digit recurrence square root, floor(sqrt(x * 2^32)), two bits a cycle
// depends on nothing beyond the timescale
`timescale 1ns / 1ps

module adam_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [47:0] root
);

  localparam int STEPS = 2;
  localparam int ITER  = 48 / STEPS;
  localparam logic [4:0] LAST = 5'(ITER - 1);

  logic [63:0] xs, xs_next;
  logic [51:0] rm, rm_next;
  logic [47:0] rt_next;
  logic [4:0]  cnt;
  logic        busy;

  always_comb begin
    logic [51:0] t;
    t       = '0;
    xs_next = xs;
    rm_next = rm;
    rt_next = root;
    for (int s = 0; s < STEPS; s++) begin
      rm_next = {rm_next[49:0], xs_next[63:62]};
      xs_next = {xs_next[61:0], 2'b00};
      t       = {2'b00, rt_next, 2'b01};
      if (rm_next >= t) begin
        rm_next = rm_next - t;
        rt_next = {rt_next[46:0], 1'b1};
      end else begin
        rt_next = {rt_next[46:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= x;
      rm   <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      xs   <= xs_next;
      rm   <= rm_next;
      root <= rt_next;
      cnt  <= cnt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LAST) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/adam_back.sv
// adam_back: moment stores, beta powers and the update sequencer with its output register
// depends on adam_pkg, adam_div, adam_sqrt
`timescale 1ns / 1ps

module adam_back #(
  parameter int PARAM_COUNT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  adam_pkg::cfg_t     cfg,
  output logic               clearing,
  input  logic               q_not_empty,
  input  adam_pkg::qitem_t   q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_index,
  output logic signed [31:0] new_value,
  output logic               saturated
);

  localparam int AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PARAM_COUNT - 1);

  adam_pkg::back_state_t state, state_next;
  adam_pkg::qitem_t cur;

  logic signed [47:0] m_store [PARAM_COUNT];
  logic [63:0]        v_store [PARAM_COUNT];
  logic signed [47:0] m_rd, mo, m_new;
  logic [63:0]        v_rd, vo, v_new;
  logic [AW-1:0]      clr_addr, rd_addr, wr_addr;
  logic               mem_we;
  logic signed [47:0] wr_m;
  logic [63:0]        wr_v;

  logic [32:0] p1, p2;
  logic [32:0] c1, c2;
  logic signed [31:0] g;
  logic signed [63:0] acc;
  logic [63:0] acc_u, gg, mhat, r;
  logic        neg, bypass;
  logic [47:0] mag;
  logic [31:0] eps_eff;
  logic        load_out;

  logic        div_start, div_done, sqrt_start, sqrt_done;
  logic [63:0] div_num, div_quo;
  logic [49:0] div_den;
  logic [47:0] sqrt_root;

  assign clearing = (state == adam_pkg::BK_CLEAR);
  assign c1       = adam_pkg::ONE_Q32 - p1;
  assign c2       = adam_pkg::ONE_Q32 - p2;
  assign mag      = m_new[47] ? 48'(-m_new) : 48'(m_new);
  assign eps_eff  = (cfg.epsilon_term == 32'd0) ? 32'd1 : cfg.epsilon_term;
  assign rd_addr  = AW'(cur.idx);
  assign wr_addr  = clearing ? clr_addr : AW'(cur.idx);
  assign wr_m     = clearing ? '0 : m_new;
  assign wr_v     = clearing ? '0 : v_new;

  // memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      m_store[wr_addr] <= wr_m;
      v_store[wr_addr] <= wr_v;
    end
    m_rd <= m_store[rd_addr];
    v_rd <= v_store[rd_addr];
  end

  adam_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  adam_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sqrt_start),
    .x    (div_quo),
    .done (sqrt_done),
    .root (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adam_pkg::BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    load_out   = 1'b0;
    div_num    = mhat;
    div_den    = {2'b00, sqrt_root} + {18'd0, eps_eff};
    case (state)
      adam_pkg::BK_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = adam_pkg::BK_IDLE;
        end
      end
      adam_pkg::BK_IDLE: begin
        if (q_not_empty) begin
          q_pop      = 1'b1;
          state_next = adam_pkg::BK_READ;
        end
      end
      adam_pkg::BK_READ: state_next = adam_pkg::BK_G;
      adam_pkg::BK_G:    state_next = adam_pkg::BK_M1;
      adam_pkg::BK_M1:   state_next = adam_pkg::BK_M2;
      adam_pkg::BK_M2:   state_next = adam_pkg::BK_GG;
      adam_pkg::BK_GG:   state_next = adam_pkg::BK_V1;
      adam_pkg::BK_V1:   state_next = adam_pkg::BK_V2;
      adam_pkg::BK_V2:   state_next = adam_pkg::BK_V3;
      adam_pkg::BK_V3:   state_next = adam_pkg::BK_V4;
      adam_pkg::BK_V4:   state_next = adam_pkg::BK_WB;
      adam_pkg::BK_WB: begin
        mem_we  = 1'b1;
        div_num = {16'd0, mag};
        div_den = {17'd0, c1};
        if (c1 == 33'd0 || c2 == 33'd0) begin
          state_next = adam_pkg::BK_FIN;
        end else begin
          div_start  = 1'b1;
          state_next = adam_pkg::BK_DIV1;
        end
      end
      adam_pkg::BK_DIV1: begin
        div_num = v_new;
        div_den = {17'd0, c2};
        if (div_done) begin
          div_start  = 1'b1;
          state_next = adam_pkg::BK_DIV2;
        end
      end
      adam_pkg::BK_DIV2: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_next = adam_pkg::BK_SQRT;
        end
      end
      adam_pkg::BK_SQRT: begin
        if (sqrt_done) begin
          div_start  = 1'b1;
          state_next = adam_pkg::BK_DIV3;
        end
      end
      adam_pkg::BK_DIV3: begin
        if (div_done) begin
          state_next = adam_pkg::BK_L1;
        end
      end
      adam_pkg::BK_L1: state_next = adam_pkg::BK_L2;
      adam_pkg::BK_L2: state_next = adam_pkg::BK_FIN;
      adam_pkg::BK_FIN: begin
        if (!out_valid) begin
          load_out   = 1'b1;
          state_next = adam_pkg::BK_IDLE;
        end
      end
      default: state_next = adam_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      p1       <= adam_pkg::ONE_Q32;
      p2       <= adam_pkg::ONE_Q32;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == adam_pkg::BK_READ && cur.start) begin
        p1 <= 33'((49'(p1) * 49'(cfg.beta_first)) >> 16);
        p2 <= 33'((49'(p2) * 49'(cfg.beta_second)) >> 16);
      end
    end
  end

  // datapath, one product per state
  always_ff @(posedge clk) begin
    logic signed [63:0] gp;
    logic signed [63:0] gs;
    gp = 64'(cur.grad) * 64'(cur.scale);
    gs = gp >>> 16;
    case (state)
      adam_pkg::BK_IDLE: begin
        if (q_not_empty) begin
          cur <= q_head;
        end
      end
      adam_pkg::BK_G: begin
        mo <= m_rd;
        vo <= v_rd;
        if (gs > 64'sd2147483647) begin
          g <= 32'sh7fffffff;
        end else if (gs < -64'sd2147483648) begin
          g <= 32'sh80000000;
        end else begin
          g <= gs[31:0];
        end
      end
      adam_pkg::BK_M1: begin
        acc <= 64'((65'(signed'({1'b0, cfg.beta_first})) * 65'(mo)) >>> 16);
      end
      adam_pkg::BK_M2: begin
        m_new <= 48'(acc + 64'(signed'({1'b0, 17'(18'h10000 - 18'(cfg.beta_first))})) *
                 64'(g));
      end
      adam_pkg::BK_GG: begin
        gg <= 64'(64'(g) * 64'(g));
      end
      adam_pkg::BK_V1: begin
        acc_u <= {48'(vo[63:32] * 48'(cfg.beta_second)), 16'd0};
      end
      adam_pkg::BK_V2: begin
        acc_u <= acc_u + 64'((48'(vo[31:0]) * 48'(cfg.beta_second)) >> 16);
      end
      adam_pkg::BK_V3: begin
        acc_u <= acc_u + {48'(49'(gg[63:32]) * 49'(17'h10000 - 17'(cfg.beta_second))), 16'd0};
      end
      adam_pkg::BK_V4: begin
        v_new <= acc_u + 64'((49'(gg[31:0]) * 49'(17'h10000 - 17'(cfg.beta_second))) >> 16);
      end
      adam_pkg::BK_WB: begin
        neg    <= m_new[47];
        bypass <= (c1 == 33'd0 || c2 == 33'd0);
      end
      adam_pkg::BK_DIV1: begin
        if (div_done) begin
          mhat <= div_quo;
        end
      end
      adam_pkg::BK_DIV3: begin
        if (div_done) begin
          r <= div_quo;
        end
      end
      adam_pkg::BK_L1: begin
        acc_u <= 64'(r[63:32]) * 64'(cfg.step_size);
      end
      adam_pkg::BK_L2: begin
        acc_u <= acc_u + 64'((64'(r[31:0]) * 64'(cfg.step_size)) >> 32);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    logic signed [49:0] sum;
    logic signed [49:0] d16;
    d16 = signed'({2'b00, acc_u[63:16]});
    sum = neg ? 50'(cur.value) + d16 : 50'(cur.value) - d16;
    if (load_out) begin
      out_index <= cur.pidx;
      if (bypass) begin
        new_value <= cur.value;
        saturated <= 1'b0;
      end else if (sum > 50'sd2147483647) begin
        new_value <= 32'sh7fffffff;
        saturated <= 1'b1;
      end else if (sum < -50'sd2147483648) begin
        new_value <= 32'sh80000000;
        saturated <= 1'b1;
      end else begin
        new_value <= sum[31:0];
        saturated <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop)
    else $error("queue popped during clearing pass");

  a_load_only_empty: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !out_valid)
    else $error("output register overwritten");

  a_powers_move_on_read: assert property (@(posedge clk) disable iff (rst)
    (state != adam_pkg::BK_READ) |=> $stable(p1) && $stable(p2))
    else $error("beta powers changed outside a step start");

  a_div_start_states: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (state == adam_pkg::BK_WB || state == adam_pkg::BK_DIV1 ||
                   state == adam_pkg::BK_SQRT))
    else $error("divider started out of sequence");

endmodule

// File: hw/rtl/adam_optimizer_update.sv
// adam_optimizer_update: top level, configuration registers, front, queue and back
// depends on adam_pkg, adam_front, adam_queue, adam_back
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// in        sink       in_valid/in_stall  param_index param_value gradient grad_mult step_start
// out       source     out_valid/out_stall out_index new_value saturated
// cfg       sink       cfg_valid/cfg_ready cfg_index cfg_data
//
// flow: the front reduces the index by a reciprocal multiply and one correction and
//   takes no new beat until it has pushed the last one into the two-entry queue; the back
//   works on one item at a time through three radix-4 divisions and a root; before any
//   step start it skips them
// reset: rst is synchronous; afterwards a clearing pass writes PARAM_COUNT zero entries
//   to both moment stores, one a cycle, with in_stall high; cfg writes are taken meanwhile
// stalls: the front keeps taking beats while a result waits in the output register, until
//   the queue is full; the back holds its finished item until that register is free

module adam_optimizer_update #(
  parameter int PARAM_COUNT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        param_index,
  input  logic signed [31:0] param_value,
  input  logic signed [31:0] gradient,
  input  logic signed [31:0] grad_mult,
  input  logic               step_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_index,
  output logic signed [31:0] new_value,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  adam_pkg::cfg_t   cfg;
  adam_pkg::qitem_t push_item, q_head;
  logic clearing, push, q_full, q_pop, q_not_empty;

  // registers are always writable; writes beyond the list fall through
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_size    <= adam_pkg::LR_RESET;
      cfg.beta_first   <= adam_pkg::BF_RESET;
      cfg.beta_second  <= adam_pkg::BS_RESET;
      cfg.epsilon_term <= adam_pkg::EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        adam_pkg::CFG_STEP_SIZE:    cfg.step_size    <= cfg_data;
        adam_pkg::CFG_BETA_FIRST:   cfg.beta_first   <= cfg_data[15:0];
        adam_pkg::CFG_BETA_SECOND:  cfg.beta_second  <= cfg_data[15:0];
        adam_pkg::CFG_EPSILON_TERM: cfg.epsilon_term <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front: accept and reduce the index
  adam_front #(.PARAM_COUNT(PARAM_COUNT)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .param_index(param_index),
    .param_value(param_value),
    .gradient   (gradient),
    .grad_mult  (grad_mult),
    .step_start (step_start),
    .clearing   (clearing),
    .push       (push),
    .push_item  (push_item),
    .q_full     (q_full)
  );

  // decoupling queue
  adam_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  // back: moments, bias correction, divide, root, rate
  adam_back #(.PARAM_COUNT(PARAM_COUNT)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .clearing   (clearing),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_index  (out_index),
    .new_value  (new_value),
    .saturated  (saturated)
  );

endmodule

// File: test/testbench.sv
// testbench: self-checking bench for the adam optimizer update block
// drives random and directed parameter beats, predicts each update bit-exactly
// depends on adam_pkg and adam_optimizer_update
`timescale 1ns / 1ps

module testbench;

  localparam int QUIET_LIMIT = 40000;  // clearing pass, long hold-off and slow items fit many times
  localparam int SLOTS = 4096;

  // one parameter beat as offered to the block
  typedef struct {
    logic [11:0]        idx;
    logic signed [31:0] value;
    logic signed [31:0] grad;
    logic signed [31:0] scale;
    logic               start;
  } param_beat_t;

  // one updated parameter as the block should return it
  typedef struct {
    logic [11:0]        idx;
    logic signed [31:0] value;
    logic               sat;
  } update_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [11:0]        param_index;
  logic signed [31:0] param_value;
  logic signed [31:0] gradient;
  logic signed [31:0] grad_mult;
  logic               step_start;
  logic               out_valid;
  logic               out_stall;
  logic [11:0]        out_index;
  logic signed [31:0] new_value;
  logic               saturated;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_index;
  logic [31:0]        cfg_data;

  adam_optimizer_update dut (.*);

  // predictor state: its own copy of the registers, moments and beta powers
  logic [31:0]          rate_q32;
  logic [15:0]          decay1_q16;
  logic [15:0]          decay2_q16;
  logic [31:0]          guard_q32;
  longint               mean_store [SLOTS];
  longint unsigned      energy_store [SLOTS];
  longint unsigned      decay1_pow;
  longint unsigned      decay2_pow;

  param_beat_t send_q[$];
  update_t     update_q[$];

  int  beats_queued;
  int  updates_seen;
  int  mismatches;
  int  quiet_cycles;
  int  send_gap;
  int  recv_gap;
  int  hold_left;
  bit  send_burst;
  bit  recv_burst;
  bit  in_taken;
  bit  out_taken;
  bit  any_beat;

  param_beat_t beat_now;
  update_t     got_upd;
  update_t     want_upd;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(num * 2^32 / den), clipped to 64 bits
  function automatic longint unsigned quot_q32(longint unsigned num, longint unsigned den);
    logic [95:0] q;
    q = {num, 32'h0} / {32'h0, den};
    return (q[95:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
  endfunction

  // floor(sqrt(x * 2^32)) by restoring digit recurrence
  function automatic longint unsigned root_q32(longint unsigned x);
    logic [95:0]     n;
    longint unsigned rem;
    longint unsigned root;
    longint unsigned trial;
    n = {x, 32'h0};
    rem = 0;
    root = 0;
    for (int i = 0; i < 48; i++) begin
      rem = (rem << 2) | n[95 - 2 * i -: 2];
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // 64-bit times 16-bit over 2^16, split in halves as the hardware does
  function automatic longint unsigned scale_q16(longint unsigned a, longint unsigned c);
    return (((a >> 32) * c) << 16) + (((a & 64'hFFFF_FFFF) * c) >> 16);
  endfunction

  // adam step for one beat; updates moments and powers
  function automatic update_t adam_update(param_beat_t b);
    update_t         u;
    longint          g;
    longint          m;
    longint          d16;
    longint          res;
    longint unsigned v;
    longint unsigned c1;
    longint unsigned c2;
    longint unsigned mag;
    longint unsigned mhat;
    longint unsigned vhat;
    longint unsigned den;
    longint unsigned ratio;
    longint unsigned delta;
    longint unsigned lr;
    int              slot;
    slot = b.idx % SLOTS;
    if (b.start) begin
      decay1_pow = (decay1_pow * decay1_q16) >> 16;
      decay2_pow = (decay2_pow * decay2_q16) >> 16;
    end
    g = (longint'(b.grad) * longint'(b.scale)) >>> 16;
    if (g > 64'sd2147483647) g = 64'sd2147483647;
    if (g < -64'sd2147483648) g = -64'sd2147483648;
    m = ((longint'(decay1_q16) * mean_store[slot]) >>> 16)
        + (65536 - longint'(decay1_q16)) * g;
    mean_store[slot] = m;
    v = scale_q16(energy_store[slot], decay2_q16)
        + scale_q16(longint'(g * g), 65536 - longint'(decay2_q16));
    energy_store[slot] = v;
    c1 = 64'h1_0000_0000 - decay1_pow;
    c2 = 64'h1_0000_0000 - decay2_pow;
    res = b.value;
    u.sat = 1'b0;
    // no step started yet: the value passes through untouched
    if (c1 != 0 && c2 != 0) begin
      mag = (m < 0) ? longint'(-m) : m;
      mhat = quot_q32(mag, c1);
      vhat = quot_q32(v, c2);
      den = root_q32(vhat) + ((guard_q32 == 0) ? 1 : guard_q32);
      ratio = quot_q32(mhat, den);
      lr = rate_q32;
      delta = (ratio >> 32) * lr + (((ratio & 64'hFFFF_FFFF) * lr) >> 32);
      d16 = delta >> 16;
      res = (m < 0) ? res + d16 : res - d16;
      if (res > 64'sd2147483647) begin
        res = 64'sd2147483647;
        u.sat = 1'b1;
      end else if (res < -64'sd2147483648) begin
        res = -64'sd2147483648;
        u.sat = 1'b1;
      end
    end
    u.idx = b.idx;
    u.value = res[31:0];
    return u;
  endfunction

  // sender: next beat goes out at the falling edge after its gap has run down
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_taken || !in_valid) begin
      if (in_taken) begin
        in_taken = 1'b0;
        send_gap = send_burst ? 0 : $urandom_range(0, 17);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (send_q.size() > 0) begin
        beat_now = send_q.pop_front();
        param_index <= beat_now.idx;
        param_value <= beat_now.value;
        gradient    <= beat_now.grad;
        grad_mult   <= beat_now.scale;
        step_start  <= beat_now.start;
        in_valid    <= 1'b1;
        send_gap = send_burst ? 0 : $urandom_range(0, 17);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall per result, plus the long hold-off when asked
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken = 1'b0;
        recv_gap = recv_burst ? 0 : $urandom_range(0, 17);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: predicts on each input beat, checks each result beat, watches for a hang
  always @(posedge clk) begin
    if (!rst) begin
      any_beat = 1'b0;
      if (in_valid && !in_stall) begin
        beat_now.idx   = param_index;
        beat_now.value = param_value;
        beat_now.grad  = gradient;
        beat_now.scale = grad_mult;
        beat_now.start = step_start;
        update_q.push_back(adam_update(beat_now));
        in_taken = 1'b1;
        any_beat = 1'b1;
      end
      if (out_valid && !out_stall) begin
        out_taken = 1'b1;
        any_beat = 1'b1;
        updates_seen++;
        got_upd.idx = out_index;
        got_upd.value = new_value;
        got_upd.sat = saturated;
        if (update_q.size() == 0) begin
          $error("result beat with nothing expected: index %0d", out_index);
          mismatches++;
        end else begin
          want_upd = update_q.pop_front();
          if (got_upd.idx !== want_upd.idx) begin
            $error("out_index: expected %0d, got %0d", want_upd.idx, got_upd.idx);
            mismatches++;
          end
          if (got_upd.value !== want_upd.value) begin
            $error("new_value: expected %0d, got %0d", want_upd.value, got_upd.value);
            mismatches++;
          end
          if (got_upd.sat !== want_upd.sat) begin
            $error("saturated: expected %0d, got %0d", want_upd.sat, got_upd.sat);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) any_beat = 1'b1;
      quiet_cycles = any_beat ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // register write; indexes off the list are dropped by the block
  task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      adam_pkg::CFG_STEP_SIZE:    rate_q32 = data;
      adam_pkg::CFG_BETA_FIRST:   decay1_q16 = data[15:0];
      adam_pkg::CFG_BETA_SECOND:  decay2_q16 = data[15:0];
      adam_pkg::CFG_EPSILON_TERM: guard_q32 = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] lr, input logic [31:0] b1, input logic [31:0] b2,
                          input logic [31:0] eps);
    write_reg(adam_pkg::CFG_STEP_SIZE, lr);
    write_reg(adam_pkg::CFG_BETA_FIRST, b1);
    write_reg(adam_pkg::CFG_BETA_SECOND, b2);
    write_reg(adam_pkg::CFG_EPSILON_TERM, eps);
    write_reg(8'd4 + 8'($urandom_range(0, 251)), $urandom);
  endtask

  task automatic add_beat(input logic [11:0] idx, input logic [31:0] value,
                          input logic [31:0] grad, input logic [31:0] scale,
                          input logic start);
    param_beat_t b;
    b.idx = idx;
    b.value = value;
    b.grad = grad;
    b.scale = scale;
    b.start = start;
    send_q.push_back(b);
    beats_queued++;
  endtask

  // random word, often shrunk so moments stay in a useful range
  function automatic logic [31:0] rand_word();
    logic signed [31:0] w;
    w = $urandom;
    return ($urandom_range(0, 3) == 0) ? w : w >>> $urandom_range(4, 20);
  endfunction

  // well-formed steps: a step-start beat then a run of beats; some steps broken
  task automatic add_steps(input int count);
    int          made;
    int          run;
    logic [11:0] idx;
    logic [31:0] scale;
    made = 0;
    while (made < count) begin
      run = $urandom_range(1, 12);
      for (int i = 0; i < run && made < count; i++) begin
        case ($urandom_range(0, 9))
          0, 1:    idx = 12'($urandom_range(0, 4095));
          2:       idx = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
          default: idx = 12'($urandom_range(0, 15));
        endcase
        scale = ($urandom_range(0, 9) < 7) ? 32'h0001_0000 : rand_word();
        add_beat(idx, rand_word(), rand_word(), scale,
                 (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0));
        made++;
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (updates_seen != beats_queued) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    param_index = '0;
    param_value = '0;
    gradient = '0;
    grad_mult = '0;
    step_start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_taken = 1'b0;
    out_taken = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    hold_left = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    beats_queued = 0;
    updates_seen = 0;
    mismatches = 0;
    quiet_cycles = 0;
    rate_q32 = adam_pkg::LR_RESET;
    decay1_q16 = adam_pkg::BF_RESET;
    decay2_q16 = adam_pkg::BS_RESET;
    guard_q32 = adam_pkg::EPS_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      mean_store[i] = 0;
      energy_store[i] = 0;
    end
    decay1_pow = 64'h1_0000_0000;
    decay2_pow = 64'h1_0000_0000;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // before any step start the correction is zero and values pass through
    add_beat(12'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    add_beat(12'd4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_beat(12'd1, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 1'b0);
    // first real step with default rates
    add_beat(12'd1, 32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 1'b1);
    add_beat(12'd0, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    add_beat(12'd4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0);
    add_beat(12'd2, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0);
    add_beat(12'd1, 32'h0002_0000, 32'h0000_8000, 32'hFFFF_0000, 1'b1);
    add_beat(12'd3, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001, 1'b0);
    add_beat(12'd1, 32'h0003_0000, 32'hFFFF_8000, 32'h0001_0000, 1'b1);
    add_steps(170);
    drain();

    // random settings around the usual decays, bursts on both sides
    for (int p = 0; p < 2; p++) begin
      set_regs($urandom_range(0, 32'h00FF_FFFF), $urandom_range(50000, 65535),
               $urandom_range(60000, 65535), $urandom_range(0, 32'h0000_FFFF));
      send_burst = (p == 0);
      recv_burst = (p == 1);
      add_steps(180);
      drain();
    end
    send_burst = 1'b0;
    recv_burst = 1'b0;

    // receiver holds off for a long stretch while the sender keeps offering
    set_regs($urandom, $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom);
    @(posedge clk);
    hold_left = 2500;
    add_steps(180);
    drain();

    // largest rate, zero first decay, full second decay, zero epsilon
    set_regs(32'hFFFF_FFFF, 32'd0, 32'd65535, 32'd0);
    add_beat(12'd7, 32'h7FFF_0000, 32'h8000_0000, 32'h0001_0000, 1'b1);
    add_beat(12'd8, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0);
    add_steps(180);
    drain();

    // zero rate, full first decay, zero second decay, largest epsilon
    set_regs(32'd0, 32'd65535, 32'd0, 32'hFFFF_FFFF);
    add_steps(180);
    drain();

    repeat (400) @(negedge clk);
    if (mismatches == 0 && update_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
